/* rtl/tlrf_pkg.sv */
// ---------------------------------------------------------------------------
// tlrf_pkg
// Shared types, constants and helpers of the text line record framer.
// ---------------------------------------------------------------------------
`default_nettype none

package tlrf_pkg;

  // Default longest stored line (characters kept per line).
  localparam int LINE_MAX_DEF = 255;

  // File limits
  localparam logic [16:0] FILE_MAX  = 17'd65535;
  localparam logic [13:0] LINES_MAX = 14'd10000;
  localparam logic [16:0] LEN_RESET = 17'd15;
  localparam logic [16:0] LEN_SAT   = 17'd65536;
  localparam logic [13:0] LINES_SAT = 14'h3FFF;
  localparam logic [13:0] NUM_SAT   = 14'd10000;
  localparam logic [13:0] NUM_MAX   = 14'd9999;

  // Characters
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Fixed end-of-file record, first byte lowest
  localparam logic [39:0] EOF_REC   = 40'h0E8A02A999;
  localparam logic [3:0]  EOF_BYTES = 4'd5;

  // Error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_ORDER  = 3'd1;
  localparam logic [2:0] ERR_SYNTAX = 3'd2;
  localparam logic [2:0] ERR_NUMBER = 3'd3;
  localparam logic [2:0] ERR_LONG   = 3'd4;
  localparam logic [2:0] ERR_FILE   = 3'd5;
  localparam logic [2:0] ERR_LINES  = 3'd6;

  // Register map (byte addresses)
  localparam logic [2:0] ADDR_USE_GIVEN = 3'd0;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } text_item_t;

  typedef struct packed {
    logic [63:0] packed_bytes;
    logic [3:0]  byte_count;
    logic        last_of_record;
    logic        record_kind;
    logic [2:0]  error_code;
    logic        error_seen;
    logic [16:0] file_bytes;
  } rec_word_t;

  // Control from the sequencer to the output stage
  typedef struct packed {
    logic        load;
    logic        eof;
    logic        first;
    logic [23:0] hdr;
    logic [3:0]  count;
    logic        last;
    logic [2:0]  err;
    logic        seen;
    logic [16:0] flen;
  } emit_ctl_t;

  // Four-digit BCD increment, wraps 9999 to 0
  function automatic logic [15:0] bcd_inc(input logic [15:0] v);
    logic [15:0] r;
    logic        carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (carry) begin
        if (r[i*4 +: 4] == 4'd9) begin
          r[i*4 +: 4] = 4'd0;
        end else begin
          r[i*4 +: 4] = r[i*4 +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tlrf_line_mem.sv */
// ---------------------------------------------------------------------------
// tlrf_line_mem
// Line content store: 64-bit rows, byte-lane writes, registered row reads.
// ---------------------------------------------------------------------------
`default_nettype none

module tlrf_line_mem #(
  parameter int ROWS = 32,
  parameter int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [2:0]    wlane,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [63:0]   rdata
);

  logic [63:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][{wlane, 3'b000} +: 8] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/tlrf_word_out.sv */
// ---------------------------------------------------------------------------
// tlrf_word_out
// Assembles record words from header, row data and the carried high bytes,
// and holds them in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tlrf_word_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tlrf_pkg::emit_ctl_t ctl,
  input  wire logic [63:0]        rdata,
  output logic                    free,
  output logic                    rec_valid,
  input  wire logic               rec_stall,
  output tlrf_pkg::rec_word_t     rec_word
);

  logic [23:0] prev_hi;
  logic [63:0] word_raw;
  logic [63:0] word_mask;

  assign free = !rec_valid || !rec_stall;

  always_comb begin
    if (ctl.eof) begin
      word_raw = {24'd0, tlrf_pkg::EOF_REC};
    end else if (ctl.first) begin
      word_raw = {rdata[39:0], ctl.hdr};
    end else begin
      word_raw = {rdata[39:0], prev_hi};
    end
    // zero lanes past the byte count
    for (int j = 0; j < 8; j++) begin
      word_mask[j*8 +: 8] = (4'(j) < ctl.count) ? word_raw[j*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (ctl.load) begin
      rec_valid <= 1'b1;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rec_word.packed_bytes   <= word_mask;
      rec_word.byte_count     <= ctl.count;
      rec_word.last_of_record <= ctl.last;
      rec_word.record_kind    <= ctl.eof;
      rec_word.error_code     <= ctl.err;
      rec_word.error_seen     <= ctl.seen;
      rec_word.file_bytes     <= ctl.flen;
      if (!ctl.eof) begin
        prev_hi <= rdata[63:40];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/text_line_record_framer.sv */
// ---------------------------------------------------------------------------
// text_line_record_framer
// Frames newline-ended text lines as records (BCD line number, length,
// content) in 64-bit words, checks numbering and size, and closes each file
// with the fixed end-of-file record.
// ---------------------------------------------------------------------------
//
//   channel  | signals                              | role
//   ---------+--------------------------------------+--------------------------
//   text     | text_valid, text_stall, text_item    | in: one char or end mark
//   rec      | rec_valid, rec_stall, rec_word       | out: record words
//   apb      | psel penable pwrite paddr pwdata ... | cfg: use_given_numbers
//
// A text byte that does not end a line is taken in the run state. A line end
// passes the close state, then ceil((n+3)/8) words go out for n stored
// characters; the line memory delivers one 64-bit row per cycle, unless the
// output stalls, through its single read port, which paces emission. End of
// input adds the end-of-file word. A stalled output holds the sequencer in
// place. Reset is synchronous and leaves the block ready for a new file.
// ---------------------------------------------------------------------------
`default_nettype none

module text_line_record_framer #(
  parameter int LINE_MAX = tlrf_pkg::LINE_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  // text in
  input  wire logic                 text_valid,
  output logic                      text_stall,
  input  wire tlrf_pkg::text_item_t text_item,
  // record words out
  output logic                      rec_valid,
  input  wire logic                 rec_stall,
  output tlrf_pkg::rec_word_t       rec_word
);

  localparam int ROWS = (LINE_MAX + 7) / 8;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [1:0] {
    S_RUN,
    S_CLOSE,
    S_EMIT,
    S_EOF
  } state_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_BLANK,
    PH_NUM,
    PH_BODY
  } phase_t;

  // ---- registers ----
  state_t      state;
  phase_t      phase;
  logic        use_given;
  logic [7:0]  char_count;
  logic [13:0] accum;        // parsed value, saturates at 10000
  logic [15:0] num_bcd;      // last four digits seen, BCD
  logic [15:0] cur_bcd;      // accepted line number, BCD
  logic [13:0] prev_num;
  logic        prev_valid;
  logic [13:0] line_total;
  logic [15:0] count_bcd;    // line_total mod 10000, BCD
  logic [16:0] length_total;
  logic        overflow;
  logic        sticky;
  logic [2:0]  line_error;
  logic        eof_pending;
  logic [23:0] hdr;
  logic [2:0]  rec_err;
  logic [8:0]  rem;          // record bytes still to send
  logic        first;
  logic [5:0]  row;          // next memory row to fetch

  // ---- step logic signals ----
  logic        take;
  logic        eoi;
  logic        is_digit;
  logic        is_space;
  logic [3:0]  dval;
  logic [17:0] acc_wide;
  logic [13:0] acc_sat;
  logic [2:0]  judge;
  phase_t      ph_n;
  logic [13:0] acc_n;
  logic [15:0] nbcd_n;
  logic [15:0] cur_n;
  logic [13:0] pnum_n;
  logic        pv_n;
  logic [2:0]  le_n;
  logic [7:0]  cnt_n;
  logic        ovf_n;
  logic        flagged;
  logic        content;
  logic        line_end;
  logic        flush;
  logic        step_we;

  // ---- close / emit signals ----
  logic [15:0] close_bcd;
  logic [13:0] lt_n;
  logic [16:0] len_sum;
  logic [16:0] len_n;
  logic [2:0]  close_err;
  logic [3:0]  emit_count;
  logic        emit_last;
  logic [2:0]  eof_err;

  // ---- datapath links ----
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       raddr;
  logic [63:0]         rdata;
  logic                free;
  tlrf_pkg::emit_ctl_t ctl;

  function automatic logic [2:0] keep_first(input logic [2:0] cur, input logic [2:0] code);
    return (cur != tlrf_pkg::ERR_NONE) ? cur : code;
  endfunction

  function automatic logic [2:0] file_err(input logic [16:0] len, input logic [13:0] lines);
    if (len > tlrf_pkg::FILE_MAX) begin
      return tlrf_pkg::ERR_FILE;
    end else if (lines > tlrf_pkg::LINES_MAX) begin
      return tlrf_pkg::ERR_LINES;
    end
    return tlrf_pkg::ERR_NONE;
  endfunction

  // ---- configuration port ----
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr == tlrf_pkg::ADDR_USE_GIVEN) begin
      prdata = {31'd0, use_given};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_given <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr == tlrf_pkg::ADDR_USE_GIVEN) begin
      use_given <= pwdata[0];
    end
  end

  // ---- input side ----
  // Take a character only while no record is being closed or sent.
  assign text_stall = (state != S_RUN);
  assign take       = text_valid && (state == S_RUN);
  assign eoi        = text_item.end_of_input;
  assign is_digit   = (text_item.text_byte >= tlrf_pkg::CH_ZERO)
                      && (text_item.text_byte <= tlrf_pkg::CH_NINE);
  // the end mark judges a pending number as if a non-space followed
  assign is_space   = (text_item.text_byte == tlrf_pkg::CH_SPACE) && !eoi;
  assign dval       = text_item.text_byte[3:0];

  // accum * 10 + digit, saturating
  assign acc_wide = 18'({accum, 3'b000}) + 18'({accum, 1'b0}) + 18'(dval);
  assign acc_sat  = (acc_wide > 18'(tlrf_pkg::NUM_SAT)) ? tlrf_pkg::NUM_SAT
                                                        : acc_wide[13:0];

  // Number check on the byte that ends the digit run: order first, then
  // range, then the separating space.
  always_comb begin
    if (prev_valid && accum <= prev_num) begin
      judge = tlrf_pkg::ERR_ORDER;
    end else if (accum > tlrf_pkg::NUM_MAX) begin
      judge = tlrf_pkg::ERR_NUMBER;
    end else if (!is_space) begin
      judge = tlrf_pkg::ERR_SYNTAX;
    end else begin
      judge = tlrf_pkg::ERR_NONE;
    end
  end

  // Per-character step: line number parsing, then content storage.
  always_comb begin
    ph_n     = phase;
    acc_n    = accum;
    nbcd_n   = num_bcd;
    cur_n    = cur_bcd;
    pnum_n   = prev_num;
    pv_n     = prev_valid;
    le_n     = line_error;
    cnt_n    = char_count;
    ovf_n    = overflow;
    flagged  = 1'b0;
    content  = 1'b0;
    line_end = 1'b0;
    flush    = 1'b0;
    step_we  = 1'b0;
    if (eoi) begin
      if (phase == PH_BLANK) begin
        le_n    = keep_first(le_n, tlrf_pkg::ERR_NUMBER);
        flagged = 1'b1;
      end else if (phase == PH_NUM) begin
        // never passes: no space follows
        le_n    = keep_first(le_n, judge);
        flagged = 1'b1;
      end else if (phase == PH_BODY && char_count != 8'd0) begin
        flush = 1'b1;
      end
    end else begin
      case (phase)
        PH_START, PH_BLANK: begin
          if (use_given) begin
            if (is_space) begin
              ph_n = PH_BLANK;
            end else if (is_digit) begin
              ph_n   = PH_NUM;
              acc_n  = {10'd0, dval};
              nbcd_n = {12'd0, dval};
            end else begin
              // no number at line start: keep the byte as content
              le_n    = keep_first(le_n, tlrf_pkg::ERR_NUMBER);
              flagged = 1'b1;
              ph_n    = PH_BODY;
              content = 1'b1;
            end
          end else begin
            ph_n    = PH_BODY;
            content = 1'b1;
          end
        end
        PH_NUM: begin
          if (is_digit) begin
            acc_n  = acc_sat;
            nbcd_n = {num_bcd[11:0], dval};
          end else begin
            ph_n = PH_BODY;
            if (judge == tlrf_pkg::ERR_NONE) begin
              // accept the number, drop the space
              cur_n  = num_bcd;
              pnum_n = accum;
              pv_n   = 1'b1;
            end else begin
              le_n    = keep_first(le_n, judge);
              flagged = 1'b1;
              content = 1'b1;
            end
          end
        end
        default: begin
          content = 1'b1;
        end
      endcase
      if (content) begin
        if (text_item.text_byte == tlrf_pkg::CH_NL) begin
          line_end = 1'b1;
        end else if (char_count < 8'(LINE_MAX) && !overflow) begin
          step_we = 1'b1;
          cnt_n   = char_count + 8'd1;
        end else begin
          // drop the rest of an over-long line
          le_n    = keep_first(le_n, tlrf_pkg::ERR_LONG);
          flagged = 1'b1;
          ovf_n   = 1'b1;
        end
      end
    end
  end

  // ---- record close: number, totals and error of the finished line ----
  assign close_bcd = use_given ? cur_bcd : count_bcd;
  assign lt_n      = (line_total != tlrf_pkg::LINES_SAT) ? line_total + 14'd1 : line_total;
  assign len_sum   = length_total + 17'(char_count) + 17'd3;
  assign len_n     = (len_sum > tlrf_pkg::LEN_SAT) ? tlrf_pkg::LEN_SAT : len_sum;
  assign close_err = keep_first(line_error, file_err(len_n, lt_n));

  // ---- emission ----
  assign emit_count = (rem > 9'd8) ? 4'd8 : rem[3:0];
  assign emit_last  = (rem <= 9'd8);
  assign eof_err    = keep_first(line_error, file_err(length_total, line_total));

  // Memory ports: writes only while taking text, reads only while closing
  // or sending, so a row is never read and written in the same cycle.
  assign mem_we = take && step_we;
  assign mem_re = (state == S_CLOSE)
                  || (state == S_EMIT && free && !emit_last && row < 6'(ROWS));
  assign raddr  = (state == S_CLOSE) ? '0 : row[AW-1:0];

  always_comb begin
    ctl = '0;
    unique case (state)
      S_EMIT: begin
        ctl.load  = free;
        ctl.first = first;
        ctl.hdr   = hdr;
        ctl.count = emit_count;
        ctl.last  = emit_last;
        ctl.err   = rec_err;
        ctl.seen  = sticky;
        ctl.flen  = length_total;
      end
      S_EOF: begin
        ctl.load  = free;
        ctl.eof   = 1'b1;
        ctl.count = tlrf_pkg::EOF_BYTES;
        ctl.last  = 1'b1;
        ctl.err   = eof_err;
        ctl.seen  = sticky || (eof_err != tlrf_pkg::ERR_NONE);
        ctl.flen  = length_total;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      phase        <= PH_START;
      char_count   <= '0;
      accum        <= '0;
      num_bcd      <= '0;
      cur_bcd      <= '0;
      prev_num     <= '0;
      prev_valid   <= 1'b0;
      line_total   <= '0;
      count_bcd    <= '0;
      length_total <= tlrf_pkg::LEN_RESET;
      overflow     <= 1'b0;
      sticky       <= 1'b0;
      line_error   <= tlrf_pkg::ERR_NONE;
      eof_pending  <= 1'b0;
      hdr          <= '0;
      rec_err      <= tlrf_pkg::ERR_NONE;
      rem          <= '0;
      first        <= 1'b0;
      row          <= '0;
    end else begin
      unique case (state)
        S_RUN: begin
          if (take) begin
            phase       <= ph_n;
            accum       <= acc_n;
            num_bcd     <= nbcd_n;
            cur_bcd     <= cur_n;
            prev_num    <= pnum_n;
            prev_valid  <= pv_n;
            line_error  <= le_n;
            char_count  <= cnt_n;
            overflow    <= ovf_n;
            sticky      <= sticky || flagged;
            eof_pending <= eoi;
            if (eoi) begin
              state <= flush ? S_CLOSE : S_EOF;
            end else if (line_end) begin
              state <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          // row 0 is fetched in this cycle
          hdr          <= {char_count, close_bcd};
          rem          <= 9'(char_count) + 9'd3;
          first        <= 1'b1;
          row          <= 6'd1;
          rec_err      <= close_err;
          sticky       <= sticky || (close_err != tlrf_pkg::ERR_NONE);
          line_total   <= lt_n;
          length_total <= len_n;
          if (line_total != tlrf_pkg::LINES_SAT) begin
            count_bcd <= tlrf_pkg::bcd_inc(count_bcd);
          end
          // start the next line
          phase        <= PH_START;
          char_count   <= '0;
          accum        <= '0;
          num_bcd      <= '0;
          cur_bcd      <= '0;
          overflow     <= 1'b0;
          line_error   <= tlrf_pkg::ERR_NONE;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (free) begin
            rem   <= rem - 9'(emit_count);
            first <= 1'b0;
            if (emit_last) begin
              state <= eof_pending ? S_EOF : S_RUN;
            end else begin
              row <= row + 6'd1;
            end
          end
        end
        S_EOF: begin
          if (free) begin
            sticky       <= sticky || (eof_err != tlrf_pkg::ERR_NONE);
            // a new file begins
            phase        <= PH_START;
            char_count   <= '0;
            accum        <= '0;
            num_bcd      <= '0;
            cur_bcd      <= '0;
            prev_num     <= '0;
            prev_valid   <= 1'b0;
            line_total   <= '0;
            count_bcd    <= '0;
            length_total <= tlrf_pkg::LEN_RESET;
            overflow     <= 1'b0;
            line_error   <= tlrf_pkg::ERR_NONE;
            eof_pending  <= 1'b0;
            state        <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  // ---- datapath ----
  tlrf_line_mem #(
    .ROWS (ROWS),
    .AW   (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (char_count[AW+2:3]),
    .wlane (char_count[2:0]),
    .wdata (text_item.text_byte),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  tlrf_word_out u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rdata     (rdata),
    .free      (free),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_word  (rec_word)
  );

`ifndef SYNTHESIS
  // line memory is never read and written in the same cycle
  a_mem_excl: assert property (@(posedge clk) disable iff (rst) !(mem_we && mem_re))
    else $error("line memory read and write overlap");

  // while sending, bytes remain
  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (rem != 9'd0))
    else $error("record sender running with no bytes left");

  // end-of-file word is a single five-byte word
  a_eof_word: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_word.record_kind) |->
      (rec_word.byte_count == tlrf_pkg::EOF_BYTES && rec_word.last_of_record))
    else $error("malformed end-of-file word");

  // a reported error is also in the sticky flag
  a_err_seen: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_word.error_code != tlrf_pkg::ERR_NONE) |-> rec_word.error_seen)
    else $error("error code without sticky flag");

  // text is only taken after the last word of a record went out
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && free && emit_last && !eof_pending) |=> (state == S_RUN))
    else $error("sender did not return to text intake");
`endif

endmodule

`default_nettype wire
